/* hdl/plid_pkg.sv */
// Shared types and constants for the positional list insert/delete unit.
// No dependencies.
package plid_pkg;

   // Field widths fixed by the interface
   localparam int unsigned POS_W = 8;
   localparam int unsigned VAL_W = 32;

   // Operation codes carried on req_operation
   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_DELETE = 1'b1
   } op_type;

   // Sequencer states
   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_RUN  = 1'b1
   } state_type;

endpackage

/* hdl/positional_list_insert_delete_unit.sv */
// Positional list insert/delete unit: list store in one synchronous memory.
// Depends on plid_pkg.
//
// Each result passes the memory read register and then the output register;
// one result per cycle, max(count, 1) results in all (count taken after the item).
// A new item is taken only after the last result of the scan (busy low); the scan
// issues one memory read per list place and rewrites that place in the next cycle.
// Reset clears the count and the sequencer; the list store itself is not cleared.
// The receiver cannot stall: each result is shown for exactly one cycle.
module positional_list_insert_delete_unit
   import plid_pkg::*;
#(
   parameter int unsigned CAPACITY = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic                    req_operation,
   input  logic [POS_W-1:0]        req_position,
   input  logic signed [VAL_W-1:0] req_value,
   output logic                    rsp_valid,
   output logic signed [VAL_W-1:0] rsp_element,
   output logic                    rsp_is_empty,
   output logic                    rsp_last,
   output logic                    rsp_accepted
);

   localparam int unsigned CW = $clog2(CAPACITY + 1);
   localparam int unsigned AW = $clog2(CAPACITY);

   // Sequencer and item registers
   state_type           state_ff, state_in;
   logic [CW-1:0]       count_ff, count_in;
   logic                op_ff;
   logic [CW-1:0]       pos_ff;
   logic signed [VAL_W-1:0] val_ff;
   logic                ok_ff;
   logic [CW-1:0]       nres_ff;
   logic                empty_ff;
   logic [CW-1:0]       iss_k_ff, iss_k_in;

   // Read-data stage
   logic                stg_vld_ff, stg_vld_in;
   logic [CW-1:0]       stg_k_ff;
   logic signed [VAL_W-1:0] rd_data_ff;
   logic signed [VAL_W-1:0] prev_ff;

   // Output registers
   logic                rsp_valid_ff;
   logic signed [VAL_W-1:0] rsp_element_ff;
   logic                rsp_is_empty_ff;
   logic                rsp_last_ff;
   logic                rsp_accepted_ff;

   logic signed [VAL_W-1:0] mem [CAPACITY];

   // Decode of the incoming item
   logic                accept;
   logic                full;
   logic                req_ok;
   logic [CW-1:0]       req_pos_clamped;
   logic [CW-1:0]       new_count;
   logic                pos_beyond;
   logic                pos_below;

   // Scan datapath
   logic                issue;
   logic [CW-1:0]       rd_addr_w;
   logic                stg_last;
   logic signed [VAL_W-1:0] new_elem;
   logic                wr_en;

   assign accept     = start && (state_ff == ST_IDLE);
   assign full       = (count_ff >= CW'(CAPACITY));
   assign pos_beyond = (req_position > POS_W'(count_ff));
   assign pos_below  = (req_position < POS_W'(count_ff));
   assign req_pos_clamped = pos_beyond ? count_ff : req_position[CW-1:0];

   // Work out acceptance and the count after the item
   always_comb begin
      req_ok    = 1'b0;
      new_count = count_ff;
      unique case (op_type'(req_operation))
         OP_INSERT: begin
            req_ok = !full;
            if (!full) new_count = count_ff + CW'(1);
         end
         OP_DELETE: begin
            req_ok = pos_below;
            if (pos_below) new_count = count_ff - CW'(1);
         end
         default: begin
            req_ok    = 1'b0;
            new_count = count_ff;
         end
      endcase
   end

   // Issue one read per result while the scan runs over a non-empty list
   assign issue = (state_ff == ST_RUN) && (iss_k_ff < nres_ff) && !empty_ff;

   // Delete reads one place ahead from the removed position on
   always_comb begin
      rd_addr_w = iss_k_ff;
      if (ok_ff && (op_type'(op_ff) == OP_DELETE) && (iss_k_ff >= pos_ff))
         rd_addr_w = iss_k_ff + CW'(1);
   end

   assign stg_last = (stg_k_ff == nres_ff - CW'(1));

   // Form the element at this place of the new list
   always_comb begin
      new_elem = rd_data_ff;
      if (ok_ff && (op_type'(op_ff) == OP_INSERT)) begin
         priority if (stg_k_ff == pos_ff) new_elem = val_ff;
         else if (stg_k_ff > pos_ff)       new_elem = prev_ff;
         else                              new_elem = rd_data_ff;
      end
   end

   assign wr_en = stg_vld_ff && ok_ff && !empty_ff;

   // Next state of the sequencer
   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      iss_k_in   = iss_k_ff;
      stg_vld_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_RUN;
               count_in = new_count;
               iss_k_in = '0;
            end
         end
         ST_RUN: begin
            if (empty_ff) begin
               // single empty result, no memory access
               stg_vld_in = (iss_k_ff == '0);
               iss_k_in   = CW'(1);
            end else if (issue) begin
               stg_vld_in = 1'b1;
               iss_k_in   = iss_k_ff + CW'(1);
            end
            if (stg_vld_ff && stg_last) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         iss_k_ff     <= '0;
         stg_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         iss_k_ff     <= iss_k_in;
         stg_vld_ff   <= stg_vld_in;
         rsp_valid_ff <= stg_vld_ff;
      end
   end

   // Hold the item for the scan
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff    <= req_operation;
         pos_ff   <= req_pos_clamped;
         val_ff   <= req_value;
         ok_ff    <= req_ok;
         nres_ff  <= (new_count == '0) ? CW'(1) : new_count;
         empty_ff <= (new_count == '0);
      end
   end

   // Advance the read-data stage
   always_ff @(posedge clock) begin
      if (stg_vld_in) stg_k_ff <= iss_k_ff;
      if (stg_vld_ff) prev_ff  <= rd_data_ff;
   end

   // List store: one read port, one write port
   always_ff @(posedge clock) begin
      if (issue) rd_data_ff <= mem[rd_addr_w[AW-1:0]];
      if (wr_en) mem[stg_k_ff[AW-1:0]] <= new_elem;
   end

   // Register each result for its one-cycle transfer
   always_ff @(posedge clock) begin
      if (stg_vld_ff) begin
         rsp_element_ff  <= empty_ff ? '0 : new_elem;
         rsp_is_empty_ff <= empty_ff;
         rsp_last_ff     <= stg_last;
         rsp_accepted_ff <= ok_ff;
      end
   end

   assign busy         = (state_ff != ST_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_element  = rsp_element_ff;
   assign rsp_is_empty = rsp_is_empty_ff;
   assign rsp_last     = rsp_last_ff;
   assign rsp_accepted = rsp_accepted_ff;

   // The count never passes the capacity
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("list count above capacity");

   // A stage entry always lies inside the result run
   a_stage_range: assert property (@(posedge clock) disable iff (reset)
      stg_vld_ff |-> (stg_k_ff < nres_ff))
      else $error("stage index outside result run");

   // An accepted item starts a scan on the next cycle
   a_accept_run: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_RUN) && (iss_k_ff == '0))
      else $error("scan did not start after accept");

   // The last result of a run leaves the unit idle
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (stg_vld_ff && stg_last) |=> !busy && rsp_valid && rsp_last)
      else $error("run did not close on its last result");

   // Reads stay inside the store
   a_read_addr: assert property (@(posedge clock) disable iff (reset)
      issue |-> (rd_addr_w < CW'(CAPACITY)))
      else $error("read address beyond store");

endmodule
